@@ hdl/ctpd_pkg.sv @@
`default_nettype none
package ctpd_pkg;

  localparam int SetDepth = 512;
  localparam int IdxW = 10;
  localparam int CodeW = 24;

  typedef enum logic [3:0] {
    ST_PENDING  = 4'd0,
    ST_ADDED    = 4'd1,
    ST_DUP      = 4'd2,
    ST_SKIPPED  = 4'd3,
    ST_CONT_ERR = 4'd4,
    ST_EARLY    = 4'd5,
    ST_HEX_ERR  = 4'd6,
    ST_SPACE    = 4'd7,
    ST_FULL     = 4'd8,
    ST_HALTED   = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [CodeW-1:0] char_code;
    logic [IdxW-1:0]  entry_index;
  } out_beat_t;

  // beat passed from cell to cell along the search chain
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic             found;
    logic [IdxW-1:0]  index;
  } probe_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    r = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) r = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) r = c - 8'h57;
    return r[3:0];
  endfunction

  function automatic logic [7:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_val(hi), hex_val(lo)};
  endfunction

  function automatic logic is_cont(input logic [7:0] v);
    return v >= 8'h80 && v <= 8'hBF;
  endfunction

  function automatic logic [CodeW-1:0] wide_to_utf8(input logic [15:0] u);
    logic [CodeW-1:0] r;
    if ((u & 16'hF800) != 16'd0)
      r = {4'hE, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]};
    else if ((u & 16'h0700) != 16'd0)
      r = {8'd0, 3'b110, u[10:6], 2'b10, u[5:0]};
    else
      r = {16'd0, u[7:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/charset_text_parser_dedup_core.sv @@
`default_nettype none
// Character-set collector.
// Input channel in / in_valid / in_stall carries one text byte or an end
// mark per beat; output channel out / out_valid / out_stall gives exactly
// one result beat per input beat.
// Parsing is combinational; its result is registered when the beat is
// taken. A byte that completes a character sends its code down a chain of
// SetDepth compare cells, one cell a cycle; other items go straight to the
// output register. One item is in flight at a time.
// The result sits in an output register until taken; while out_stall is
// high the block holds it and accepts nothing new.
// Reset clears the parser, the count and all entry valid bits; the set is
// empty and the block is ready the cycle after reset drops. After an
// error or end of text every item reports halted until reset.
module charset_text_parser_dedup_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ctpd_pkg::in_beat_t   in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ctpd_pkg::out_beat_t       out
);
  localparam int N = ctpd_pkg::SetDepth;
  localparam int CW = ctpd_pkg::CodeW;
  localparam int IW = ctpd_pkg::IdxW;

  typedef enum logic [4:0] {
    PH_START, PH_BOM, PH_IDLE, PH_WLO, PH_WHI, PH_U2, PH_U3, PH_H1, PH_X1,
    PH_X2, PH_H3, PH_H4, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5
  } phase_t;

  typedef enum logic [1:0] {S_READY, S_SEARCH, S_OUT} ctl_t;

  phase_t phase, phase_next;
  logic wide_mode, wide_mode_next, prefix_seen, prefix_seen_next;
  logic [7:0] held_digit, held_next, first_value, first_next, second_value, second_next;
  logic halted, halted_next;
  logic [IW-1:0] entry_count;
  ctl_t ctl;
  logic [3:0] r_st;
  logic [CW-1:0] r_code;
  logic r_store;
  logic [IW-1:0] count;

  ctpd_pkg::probe_t chain [0:N];
  logic [N-1:0] wr_en;

  logic accept;
  assign in_stall = (ctl != S_READY);
  assign accept = in_valid && !in_stall;

  // parser step
  always_comb begin
    logic [7:0] b;
    logic eos, fail;
    logic [7:0] v;
    logic [15:0] u;
    b = in.in_byte;
    eos = in.end_of_stream;
    fail = eos || b == 8'd0;
    v = 8'd0;
    u = 16'd0;
    phase_next = phase;
    wide_mode_next = wide_mode;
    prefix_seen_next = prefix_seen;
    held_next = held_digit;
    first_next = first_value;
    second_next = second_value;
    halted_next = halted;
    r_st = ctpd_pkg::ST_SKIPPED;
    r_code = '0;
    r_store = 1'b0;
    if (halted) begin
      r_st = ctpd_pkg::ST_HALTED;
    end else begin
      unique case (phase)
        PH_BOM: begin
          if (eos) halted_next = 1'b1;
          else if (b == 8'hFE) begin wide_mode_next = 1'b1; phase_next = PH_WLO; end
          else phase_next = PH_IDLE;
        end
        PH_WLO: begin
          if (eos) halted_next = 1'b1;
          else begin first_next = b; phase_next = PH_WHI; r_st = ctpd_pkg::ST_PENDING; end
        end
        PH_WHI: begin
          u = {b, first_value};
          if (eos) halted_next = 1'b1;
          else begin
            phase_next = PH_WLO;
            if (u == 16'd0) halted_next = 1'b1;
            else if (!(u == 16'h0A || u == 16'h20 || u == 16'h09 || u == 16'h0D)) begin
              r_store = 1'b1; r_code = ctpd_pkg::wide_to_utf8(u);
            end
          end
        end
        PH_U2, PH_U3: begin
          phase_next = PH_IDLE;
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (!ctpd_pkg::is_cont(b)) begin
            halted_next = 1'b1; r_st = ctpd_pkg::ST_CONT_ERR;
          end else if (phase == PH_U2 && first_value >= 8'hE0) begin
            second_next = b; phase_next = PH_U3; r_st = ctpd_pkg::ST_PENDING;
          end else begin
            r_store = 1'b1;
            r_code = (phase == PH_U2) ? {8'd0, first_value, b} : {first_value, second_value, b};
          end
        end
        PH_H1: begin
          phase_next = PH_IDLE;
          if (eos) halted_next = 1'b1;
          if (fail) begin r_store = 1'b1; r_code = {16'd0, held_digit}; end
          else if (held_digit == 8'h30 && b == 8'h78) begin
            prefix_seen_next = 1'b1; phase_next = PH_X1; r_st = ctpd_pkg::ST_PENDING;
          end else if (ctpd_pkg::is_hex(b)) begin
            first_next = ctpd_pkg::pair_val(held_digit, b); prefix_seen_next = 1'b0;
            phase_next = PH_H3; r_st = ctpd_pkg::ST_PENDING;
          end
        end
        PH_X1, PH_S4: begin
          phase_next = PH_IDLE;
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (!ctpd_pkg::is_hex(b)) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_HEX_ERR; end
          else begin
            held_next = b; phase_next = (phase == PH_X1) ? PH_X2 : PH_S5;
            r_st = ctpd_pkg::ST_PENDING;
          end
        end
        PH_X2: begin
          phase_next = PH_IDLE;
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (!ctpd_pkg::is_hex(b)) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_HEX_ERR; end
          else begin
            first_next = ctpd_pkg::pair_val(held_digit, b); phase_next = PH_H3;
            r_st = ctpd_pkg::ST_PENDING;
          end
        end
        PH_H3: begin
          phase_next = PH_IDLE;
          if (fail) begin
            if (prefix_seen || first_value >= 8'hC0) begin
              halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY;
            end else begin
              if (eos) halted_next = 1'b1;
              r_store = 1'b1; r_code = {16'd0, first_value};
            end
          end else if (ctpd_pkg::is_hex(b)) begin
            held_next = b; phase_next = PH_H4; r_st = ctpd_pkg::ST_PENDING;
          end else if (first_value >= 8'hC0) begin
            if (b == 8'h20) begin phase_next = PH_S1; r_st = ctpd_pkg::ST_PENDING; end
            else begin halted_next = 1'b1; r_st = ctpd_pkg::ST_SPACE; end
          end else begin
            r_store = 1'b1; r_code = {16'd0, first_value};
          end
        end
        PH_H4: begin
          phase_next = PH_IDLE;
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (!ctpd_pkg::is_hex(b)) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_HEX_ERR; end
          else begin
            r_store = 1'b1;
            r_code = ctpd_pkg::wide_to_utf8({first_value, ctpd_pkg::pair_val(held_digit, b)});
          end
        end
        PH_S1: begin
          phase_next = PH_IDLE;
          if (fail) begin
            if (eos) halted_next = 1'b1;
            r_store = 1'b1; r_code = {16'd0, first_value};
          end else if (!ctpd_pkg::is_hex(b)) begin
            halted_next = 1'b1; r_st = ctpd_pkg::ST_HEX_ERR;
          end else begin held_next = b; phase_next = PH_S2; r_st = ctpd_pkg::ST_PENDING; end
        end
        PH_S2, PH_S5: begin
          phase_next = PH_IDLE;
          v = ctpd_pkg::pair_val(held_digit, b);
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (!ctpd_pkg::is_hex(b)) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_HEX_ERR; end
          else if (!ctpd_pkg::is_cont(v)) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_CONT_ERR; end
          else if (phase == PH_S2 && first_value >= 8'hE0) begin
            second_next = v; phase_next = PH_S3; r_st = ctpd_pkg::ST_PENDING;
          end else begin
            r_store = 1'b1;
            r_code = (phase == PH_S2) ? {8'd0, first_value, v} : {first_value, second_value, v};
          end
        end
        PH_S3: begin
          phase_next = PH_IDLE;
          if (fail) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_EARLY; end
          else if (b != 8'h20) begin halted_next = 1'b1; r_st = ctpd_pkg::ST_SPACE; end
          else begin phase_next = PH_S4; r_st = ctpd_pkg::ST_PENDING; end
        end
        default: begin
          // start of text and between tokens
          if (eos) halted_next = 1'b1;
          else if (phase == PH_START && b == 8'hFF) begin
            phase_next = PH_BOM; r_st = ctpd_pkg::ST_PENDING;
          end else begin
            phase_next = PH_IDLE;
            if (b == 8'h0A || b == 8'h20 || b == 8'h09 || b == 8'h0D) r_st = ctpd_pkg::ST_SKIPPED;
            else if (b >= 8'hC0) begin
              first_next = b; phase_next = PH_U2; r_st = ctpd_pkg::ST_PENDING;
            end else if (ctpd_pkg::is_hex(b)) begin
              held_next = b; phase_next = PH_H1; r_st = ctpd_pkg::ST_PENDING;
            end else begin r_store = 1'b1; r_code = {16'd0, b}; end
          end
        end
      endcase
    end
    // skipped codes never reach the set
    if (r_store && (r_code == 24'd0 || r_code == 24'h0A || r_code == 24'h0D ||
                    r_code == 24'h09)) begin
      r_store = 1'b0; r_code = '0; r_st = ctpd_pkg::ST_SKIPPED;
    end
  end

  logic [CW-1:0] srch_code;
  logic tail_hit;

  // search chain; the head holds the searched code for the whole search so
  // every cell sees it when the probe leaves the tail
  assign chain[0].valid = accept && r_store;
  assign chain[0].code = accept ? r_code : srch_code;
  assign chain[0].found = 1'b0;
  assign chain[0].index = '0;

  assign tail_hit = chain[N].valid;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign wr_en[g] = tail_hit && !chain[N].found && entry_count == IW'(g);
      ctpd_cell u_cell (
        .clk(clk), .rst(rst), .my_index(IW'(g)),
        .wr(wr_en[g]),
        .probe_in(chain[g]),
        .probe_out(chain[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      wide_mode <= 1'b0;
      prefix_seen <= 1'b0;
      held_digit <= 8'd0;
      first_value <= 8'd0;
      second_value <= 8'd0;
      halted <= 1'b0;
      entry_count <= '0;
      ctl <= S_READY;
      out_valid <= 1'b0;
      count <= '0;
    end else begin
      unique case (ctl)
        S_READY: begin
          if (accept) begin
            phase <= phase_next;
            wide_mode <= wide_mode_next;
            prefix_seen <= prefix_seen_next;
            held_digit <= held_next;
            first_value <= first_next;
            second_value <= second_next;
            halted <= halted_next;
            srch_code <= r_code;
            if (r_store) begin
              ctl <= S_SEARCH;
            end else begin
              out.status <= r_st;
              out.char_code <= '0;
              out.entry_index <= '0;
              out_valid <= 1'b1;
              ctl <= S_OUT;
            end
          end
        end
        S_SEARCH: begin
          if (tail_hit) begin
            out.char_code <= chain[N].code;
            out_valid <= 1'b1;
            ctl <= S_OUT;
            if (chain[N].found) begin
              out.status <= ctpd_pkg::ST_DUP;
              out.entry_index <= chain[N].index;
            end else if (entry_count == IW'(N)) begin
              out.status <= ctpd_pkg::ST_FULL;
              out.entry_index <= '0;
            end else begin
              out.status <= ctpd_pkg::ST_ADDED;
              out.entry_index <= entry_count;
              entry_count <= entry_count + 1'b1;
            end
          end
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            ctl <= S_READY;
          end
        end
      endcase
      count <= (ctl == S_SEARCH) ? count + 1'b1 : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= IW'(N)) else $error("entry count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ctl != S_READY |-> !accept) else $error("accept while busy");
  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    tail_hit |-> ctl == S_SEARCH) else $error("stray probe");
  a_search_len: assert property (@(posedge clk) disable iff (rst)
    ctl == S_SEARCH |-> count <= IW'(N)) else $error("search too long");
endmodule
`default_nettype wire

@@ hdl/ctpd_cell.sv @@
`default_nettype none
// One set entry: compares the passing probe to its stored code.
module ctpd_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ctpd_pkg::IdxW-1:0]  my_index,
  input  wire logic                       wr,
  input  wire ctpd_pkg::probe_t           probe_in,
  output ctpd_pkg::probe_t                probe_out
);
  logic [ctpd_pkg::CodeW-1:0] code;
  logic                       used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
      if (wr) used <= 1'b1;
    end
    if (wr) code <= probe_in.code;
    probe_out.code <= probe_in.code;
    if (!probe_in.found && used && code == probe_in.code) begin
      probe_out.found <= 1'b1;
      probe_out.index <= my_index;
    end else begin
      probe_out.found <= probe_in.found;
      probe_out.index <= probe_in.index;
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_charset_text_parser_dedup_core.sv @@
`timescale 1ns / 100ps
module tb_charset_text_parser_dedup_core;

  typedef enum logic [4:0] {
    P_START, P_BOM, P_IDLE, P_WLO, P_WHI, P_U2, P_U3, P_H1, P_X1, P_X2,
    P_H3, P_H4, P_S1, P_S2, P_S3, P_S4, P_S5
  } phase_t;

  localparam int NumItems = 1170;
  localparam int QuietLo = 400;
  localparam int QuietHi = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ctpd_pkg::in_beat_t in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctpd_pkg::out_beat_t out;

  ctpd_pkg::in_beat_t text_q[$];
  ctpd_pkg::out_beat_t result_q[$];
  int sent = 0;
  int got = 0;
  int mismatches = 0;

  // parser shadow
  phase_t ph;
  logic wide, pfx, halt;
  logic [7:0] held, fv, sv;
  logic [23:0] set_mem[ctpd_pkg::SetDepth];
  int set_cnt;

  charset_text_parser_dedup_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in(in),
    .out_valid(out_valid), .out_stall(out_stall), .out(out)
  );

  always #6 clk = ~clk;

  function automatic logic hexch(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nib(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic logic contb(logic [7:0] v);
    return v >= 8'h80 && v <= 8'hBF;
  endfunction

  function automatic logic [23:0] to_utf8(logic [15:0] u);
    if (u[15:11] != 0) return {4'hE, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]};
    if (u[10:8] != 0) return {8'd0, 3'b110, u[10:6], 2'b10, u[5:0]};
    return {16'd0, u[7:0]};
  endfunction

  function automatic ctpd_pkg::out_beat_t res(ctpd_pkg::status_t s,
                                              logic [23:0] c = '0, int i = 0);
    ctpd_pkg::out_beat_t r;
    r.status = s;
    r.char_code = c;
    r.entry_index = i[ctpd_pkg::IdxW-1:0];
    return r;
  endfunction

  function ctpd_pkg::out_beat_t add_code(logic [23:0] c);
    if (c == 24'h0 || c == 24'h0A || c == 24'h0D || c == 24'h09)
      return res(ctpd_pkg::ST_SKIPPED);
    for (int i = 0; i < set_cnt; i++)
      if (set_mem[i] == c) return res(ctpd_pkg::ST_DUP, c, i);
    if (set_cnt >= ctpd_pkg::SetDepth) return res(ctpd_pkg::ST_FULL, c);
    set_mem[set_cnt] = c;
    set_cnt++;
    return res(ctpd_pkg::ST_ADDED, c, set_cnt - 1);
  endfunction

  function ctpd_pkg::out_beat_t finish_tok(logic eos, logic [23:0] c);
    ph = P_IDLE;
    if (eos) halt = 1'b1;
    return add_code(c);
  endfunction

  function ctpd_pkg::out_beat_t fault(ctpd_pkg::status_t s);
    halt = 1'b1;
    ph = P_IDLE;
    return res(s);
  endfunction

  function ctpd_pkg::out_beat_t wait_more(phase_t p);
    ph = p;
    return res(ctpd_pkg::ST_PENDING);
  endfunction

  function ctpd_pkg::out_beat_t idle_in(logic [7:0] b);
    ph = P_IDLE;
    if (b == 8'h0A || b == " " || b == 8'h09 || b == 8'h0D) return res(ctpd_pkg::ST_SKIPPED);
    if (b >= 8'hC0) begin
      fv = b;
      return wait_more(P_U2);
    end
    if (hexch(b)) begin
      held = b;
      return wait_more(P_H1);
    end
    return add_code({16'd0, b});
  endfunction

  function ctpd_pkg::out_beat_t collect(ctpd_pkg::in_beat_t it);
    logic [7:0] b;
    logic eos, miss;
    logic [15:0] u;
    logic [7:0] v;
    b = it.in_byte;
    eos = it.end_of_stream;
    miss = eos || b == 8'h00;
    if (halt) return res(ctpd_pkg::ST_HALTED);
    case (ph)
      P_START: begin
        if (eos) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        if (b == 8'hFF) return wait_more(P_BOM);
        return idle_in(b);
      end
      P_BOM: begin
        if (eos) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        if (b == 8'hFE) begin wide = 1'b1; ph = P_WLO; end
        else ph = P_IDLE;
        return res(ctpd_pkg::ST_SKIPPED);
      end
      P_WLO: begin
        if (eos) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        fv = b;
        return wait_more(P_WHI);
      end
      P_WHI: begin
        if (eos) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        u = {b, fv};
        ph = P_WLO;
        if (u == 16'h0) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        if (u == 16'h0A || u == 16'h20 || u == 16'h09 || u == 16'h0D)
          return res(ctpd_pkg::ST_SKIPPED);
        return add_code(to_utf8(u));
      end
      P_U2: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!contb(b)) return fault(ctpd_pkg::ST_CONT_ERR);
        if (fv >= 8'hE0) begin sv = b; return wait_more(P_U3); end
        return finish_tok(eos, {8'd0, fv, b});
      end
      P_U3: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!contb(b)) return fault(ctpd_pkg::ST_CONT_ERR);
        return finish_tok(eos, {fv, sv, b});
      end
      P_H1: begin
        if (miss) return finish_tok(eos, {16'd0, held});
        if (held == "0" && b == "x") begin pfx = 1'b1; return wait_more(P_X1); end
        if (hexch(b)) begin
          fv = {nib(held), nib(b)};
          pfx = 1'b0;
          return wait_more(P_H3);
        end
        ph = P_IDLE;
        if (eos) halt = 1'b1;
        return res(ctpd_pkg::ST_SKIPPED);
      end
      P_X1, P_S4: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        held = b;
        return wait_more(ph == P_X1 ? P_X2 : P_S5);
      end
      P_X2: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        fv = {nib(held), nib(b)};
        return wait_more(P_H3);
      end
      P_H3: begin
        if (miss) begin
          if (pfx || fv >= 8'hC0) return fault(ctpd_pkg::ST_EARLY);
          return finish_tok(eos, {16'd0, fv});
        end
        if (hexch(b)) begin held = b; return wait_more(P_H4); end
        if (fv >= 8'hC0) begin
          if (b == " ") return wait_more(P_S1);
          return fault(ctpd_pkg::ST_SPACE);
        end
        return finish_tok(eos, {16'd0, fv});
      end
      P_H4: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        return finish_tok(eos, to_utf8({fv, nib(held), nib(b)}));
      end
      P_S1: begin
        if (miss) return finish_tok(eos, {16'd0, fv});
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        held = b;
        return wait_more(P_S2);
      end
      P_S2: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        v = {nib(held), nib(b)};
        if (!contb(v)) return fault(ctpd_pkg::ST_CONT_ERR);
        if (fv >= 8'hE0) begin sv = v; return wait_more(P_S3); end
        return finish_tok(eos, {8'd0, fv, v});
      end
      P_S3: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (b != " ") return fault(ctpd_pkg::ST_SPACE);
        return wait_more(P_S4);
      end
      P_S5: begin
        if (miss) return fault(ctpd_pkg::ST_EARLY);
        if (!hexch(b)) return fault(ctpd_pkg::ST_HEX_ERR);
        v = {nib(held), nib(b)};
        if (!contb(v)) return fault(ctpd_pkg::ST_CONT_ERR);
        return finish_tok(eos, {fv, sv, v});
      end
      default: begin
        if (eos) begin halt = 1'b1; return res(ctpd_pkg::ST_SKIPPED); end
        return idle_in(b);
      end
    endcase
  endfunction

  // ---- text generation ----
  task automatic put(logic [7:0] b, logic eos = 1'b0);
    ctpd_pkg::in_beat_t it;
    it.in_byte = b;
    it.end_of_stream = eos;
    text_q.push_back(it);
  endtask

  function automatic logic [7:0] digit(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  task automatic put_hex(logic [7:0] v);
    put(digit(v[7:4]));
    put(digit(v[3:0]));
  endtask

  // byte that is neither a hex digit nor a lead byte (C0 and up)
  function automatic logic [7:0] filler(logic allow_zero);
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: return " ";
      1: return 8'h0A;
      2: return 8'h09;
      3: return 8'h0D;
      4: if (allow_zero) return 8'h00;
      default: ;
    endcase
    do b = 8'($urandom_range(1, 8'hBF)); while (hexch(b));
    return b;
  endfunction

  task automatic put_unit(logic [15:0] u);
    put(u[7:0]);
    put(u[15:8]);
  endtask

  task automatic byte_token();
    int r;
    logic [7:0] ld;
    logic [15:0] w;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      put(8'($urandom_range(8'hC0, 8'hDF)));
      put(8'($urandom_range(8'h80, 8'hBF)));
    end else if (r < 60) begin
      put(8'($urandom_range(8'hE0, 8'hFF)));
      put(8'($urandom_range(8'h80, 8'hBF)));
      put(8'($urandom_range(8'h80, 8'hBF)));
    end else if (r < 68) begin
      put_hex(8'($urandom_range(0, 8'hBF)));
      put(filler(1'b1));
    end else if (r < 76) begin
      w = 16'($urandom);
      if ($urandom_range(0, 1)) begin put("0"); put("x"); end
      put_hex(w[15:8]);
      put_hex(w[7:0]);
    end else if (r < 86) begin
      ld = 8'($urandom_range(8'hC0, 8'hFF));
      put_hex(ld);
      put(" ");
      put_hex(8'($urandom_range(8'h80, 8'hBF)));
      if (ld >= 8'hE0) begin
        put(" ");
        put_hex(8'($urandom_range(8'h80, 8'hBF)));
      end
    end else if (r < 90) begin
      // lone digit, dropped with the byte after it
      put(digit(4'($urandom)));
      put(" ");
    end else begin
      put(filler(1'b1));
    end
  endtask

  task automatic wide_token();
    logic [15:0] u;
    u = 16'($urandom);
    if ($urandom_range(0, 9) == 0) u = {8'd0, filler(1'b0)};
    if (u == 16'h0) u = 16'h0001;
    put_unit(u);
  endtask

  task automatic build_text(logic wmode);
    if (wmode) begin
      put(8'hFF); put(8'hFE);
      put_unit(16'h0041); put_unit(16'h00E9); put_unit(16'h0100); put_unit(16'h07FF);
      put_unit(16'h0800); put_unit(16'hFFFF); put_unit(16'h000A); put_unit(16'h0041);
      while (text_q.size() < NumItems) wide_token();
      case ($urandom_range(0, 2))
        0: put(8'($urandom), 1'b1);
        1: put_unit(16'h0000);
        default: begin put(8'h33); put(8'($urandom), 1'b1); end
      endcase
    end else begin
      // mark that is not a wide one: FF reports pending, the byte after it is skipped
      put(8'hFF); put("A");
      put("0"); put(" ");
      put("4"); put("1"); put("g");
      put(8'h00); put(8'h09); put("~");
      put("C"); put("3"); put(" "); put("a"); put("4");
      put("E"); put("2"); put(" "); put("8"); put("2"); put(" "); put("A"); put("C");
      put(8'hE2); put(8'h82); put(8'hAC);
      put("0"); put("x"); put("2"); put("0"); put("a"); put("c");
      put("0"); put("0"); put("E"); put("9");
      put("7"); put(8'h00);
      while (text_q.size() < NumItems) byte_token();
      case ($urandom_range(0, 7))
        0: put(8'($urandom), 1'b1);
        1: begin put(8'hC5); put(8'h00); end
        2: begin put(8'hC5); put(8'h41); end
        3: begin put("0"); put("x"); put("g"); end
        4: begin put("C"); put("5"); put("g"); end
        5: begin put("3"); put(8'($urandom), 1'b1); end
        6: begin put("4"); put("1"); put(8'($urandom), 1'b1); end
        default: begin put("C"); put("5"); put(" "); put(8'($urandom), 1'b1); end
      endcase
    end
    repeat (6) put(8'($urandom), 1'($urandom));
  endtask

  // ---- driver ----
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(collect(in));
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (text_q.size() > 0 &&
            ((sent >= QuietLo && sent < QuietHi) || $urandom_range(0, 99) >= 30)) begin
          in_valid <= 1'b1;
          in <= text_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    ctpd_pkg::out_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d code %h index %0d",
                     out.status, out.char_code, out.entry_index);
        end else begin
          want = result_q.pop_front();
          if (out.status !== want.status || out.char_code !== want.char_code ||
              out.entry_index !== want.entry_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected status %0d code %h index %0d, got %0d %h %0d",
                       got, want.status, want.char_code, want.entry_index,
                       out.status, out.char_code, out.entry_index);
          end
        end
      end
      out_stall <= !(got >= QuietLo && got < QuietHi) && $urandom_range(0, 99) < 30;
    end
  end

  initial begin
    ph = P_START;
    wide = 1'b0;
    pfx = 1'b0;
    halt = 1'b0;
    held = '0;
    fv = '0;
    sv = '0;
    set_cnt = 0;
    build_text($urandom_range(0, 3) == 0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (text_q.size() == 0 && !in_valid);
    wait (result_q.size() == 0);
    repeat (ctpd_pkg::SetDepth + 100) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0)
      $display("PASS charset_text_parser_dedup_core");
    else
      $display("FAIL charset_text_parser_dedup_core");
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL charset_text_parser_dedup_core");
    $finish;
  end

endmodule

@@ files.f @@
hdl/ctpd_pkg.sv
hdl/ctpd_cell.sv
hdl/charset_text_parser_dedup_core.sv
tb/tb_charset_text_parser_dedup_core.sv
